// File: rtl/wbcp_pkg.sv
// Package for the weighted base consensus pileup.
// Holds sizes, character and call codes, the queued command type and the back-end states.
// No dependencies.
package wbcp_pkg;

	localparam int POSITIONS = 1024;
	localparam int COUNT_BITS = 24;
	localparam int POS_BITS = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int POS_IN_BITS = 10;
	localparam int POS_WIDE_BITS = 17;
	localparam int CHAR_BITS = 8;
	localparam int WEIGHT_BITS = 8;
	localparam int CALL_BITS = 3;
	localparam int DEPTH_BITS = 24;
	localparam int NUM_BASES = 4;
	localparam int ROW_BITS = NUM_BASES * COUNT_BITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_BITS-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_BITS-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_BITS-1:0] CHAR_T = 8'h54;

	localparam logic [CALL_BITS-1:0] CALL_N = 3'd4;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BASE_A = 2'd0,
		BASE_C = 2'd1,
		BASE_G = 2'd2,
		BASE_T = 2'd3
	} base_t;

	typedef struct packed {
		logic                   is_read;
		logic                   in_range;
		base_t                  base;
		logic [POS_BITS-1:0]    idx;
		logic [WEIGHT_BITS-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

endpackage

// File: rtl/weighted_base_consensus_pileup.sv
// Top level of the weighted base consensus pileup.
// Depends on wbcp_pkg, wbcp_front, wbcp_queue and wbcp_back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready   opcode, position, base_char, weight
//   out      output     out_valid / out_ready best_base, depth
//
// After reset a clearing pass zeroes one counter row per cycle across all 1024 rows,
// with in_ready held low.
// A feed or read takes two steps in the back end: BK_IDLE reads the row from the
// single-port memory; BK_EXEC writes it back (cleared on reads), loads read results.
// A two-entry queue lets the front end keep accepting while the back end works or
// waits for out_ready; feeds that change nothing are dropped in the front end.
module weighted_base_consensus_pileup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [wbcp_pkg::POS_IN_BITS-1:0]    position,
	input  logic [wbcp_pkg::CHAR_BITS-1:0]      base_char,
	input  logic [wbcp_pkg::WEIGHT_BITS-1:0]    weight,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wbcp_pkg::CALL_BITS-1:0]      best_base,
	output logic [wbcp_pkg::DEPTH_BITS-1:0]     depth
);

	wbcp_pkg::back_status_t status;
	logic                   push_valid;
	logic                   push_ready;
	wbcp_pkg::cmd_t         push_data;
	logic                   pop_valid;
	logic                   pop_ready;
	wbcp_pkg::cmd_t         pop_data;

	wbcp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.position   (position),
		.base_char  (base_char),
		.weight     (weight),
		.status     (status),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	wbcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	wbcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.best_base (best_base),
		.depth     (depth)
	);

endmodule

// File: rtl/wbcp_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on wbcp_pkg for the command type and queue sizes.
module wbcp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  wbcp_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output wbcp_pkg::cmd_t pop_data
);

	wbcp_pkg::cmd_t entry_q [wbcp_pkg::QUEUE_DEPTH];
	logic [wbcp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [wbcp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [wbcp_pkg::QUEUE_CNT_BITS-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != wbcp_pkg::QUEUE_CNT_BITS'(wbcp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == wbcp_pkg::QUEUE_PTR_BITS'(wbcp_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == wbcp_pkg::QUEUE_PTR_BITS'(wbcp_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/wbcp_front.sv
// Front end: accepts input items, decodes the base character and checks the position.
// Depends on wbcp_pkg; feeds that cannot change any counter are dropped here.
module wbcp_front (
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 opcode,
	input  logic [wbcp_pkg::POS_IN_BITS-1:0]     position,
	input  logic [wbcp_pkg::CHAR_BITS-1:0]       base_char,
	input  logic [wbcp_pkg::WEIGHT_BITS-1:0]     weight,
	input  wbcp_pkg::back_status_t               status,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output wbcp_pkg::cmd_t                       push_data
);

	logic                                 base_ok;
	wbcp_pkg::base_t                      base;
	logic [wbcp_pkg::POS_WIDE_BITS-1:0]   pos_wide;
	logic                                 in_range;
	logic                                 is_read;
	logic                                 useful;

	always_comb begin
		base_ok = 1'b1;
		base    = wbcp_pkg::BASE_A;
		unique case (base_char)
			wbcp_pkg::CHAR_A: base = wbcp_pkg::BASE_A;
			wbcp_pkg::CHAR_C: base = wbcp_pkg::BASE_C;
			wbcp_pkg::CHAR_G: base = wbcp_pkg::BASE_G;
			wbcp_pkg::CHAR_T: base = wbcp_pkg::BASE_T;
			default: base_ok = 1'b0;
		endcase
	end

	assign pos_wide = wbcp_pkg::POS_WIDE_BITS'(position);
	assign in_range = pos_wide < wbcp_pkg::POS_WIDE_BITS'(wbcp_pkg::POSITIONS);
	assign is_read  = (wbcp_pkg::op_t'(opcode) == wbcp_pkg::OP_READ);
	assign useful   = is_read || (in_range && base_ok && (weight != '0));

	assign in_ready   = !status.clearing && push_ready;
	assign push_valid = in_valid && !status.clearing && useful;

	always_comb begin
		push_data.is_read  = is_read;
		push_data.in_range = in_range;
		push_data.base     = base;
		push_data.idx      = pos_wide[wbcp_pkg::POS_BITS-1:0];
		push_data.weight   = weight;
	end

endmodule

// File: rtl/wbcp_back.sv
// Back end: counter memory, read-modify-write sequencer, clearing pass and result register.
// Depends on wbcp_pkg; takes commands from wbcp_queue.
module wbcp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  wbcp_pkg::cmd_t                     pop_data,
	output wbcp_pkg::back_status_t             status,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wbcp_pkg::CALL_BITS-1:0]     best_base,
	output logic [wbcp_pkg::DEPTH_BITS-1:0]    depth
);

	logic [wbcp_pkg::ROW_BITS-1:0]   mem [wbcp_pkg::POSITIONS];
	logic [wbcp_pkg::ROW_BITS-1:0]   rd_row_q;
	wbcp_pkg::cmd_t                  cmd_q;
	wbcp_pkg::back_state_t           state_q;
	wbcp_pkg::back_state_t           state_d;
	logic [wbcp_pkg::POS_BITS-1:0]   clr_q;
	logic                            clr_last;
	logic                            out_valid_q;
	logic [wbcp_pkg::CALL_BITS-1:0]  best_base_q;
	logic [wbcp_pkg::DEPTH_BITS-1:0] depth_q;

	logic                            go;
	logic                            rd_en;
	logic                            wr_en;
	logic [wbcp_pkg::POS_BITS-1:0]   wr_addr;
	logic [wbcp_pkg::ROW_BITS-1:0]   wr_data;
	logic                            load_out;

	logic [wbcp_pkg::COUNT_BITS-1:0] cnt [wbcp_pkg::NUM_BASES];
	logic [wbcp_pkg::COUNT_BITS:0]   sum;
	logic [wbcp_pkg::COUNT_BITS-1:0] sat;
	logic [wbcp_pkg::ROW_BITS-1:0]   fed_row;
	logic [1:0]                      best;
	logic                            any_vote;
	logic [wbcp_pkg::CALL_BITS-1:0]  call;
	logic [wbcp_pkg::DEPTH_BITS-1:0] call_depth;

	assign clr_last = (clr_q == wbcp_pkg::POS_BITS'(wbcp_pkg::POSITIONS - 1));
	assign go       = !cmd_q.is_read || !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < wbcp_pkg::NUM_BASES; i++) begin
			cnt[i] = rd_row_q[i*wbcp_pkg::COUNT_BITS +: wbcp_pkg::COUNT_BITS];
		end
	end

	always_comb begin
		sum = {1'b0, cnt[cmd_q.base]} + (wbcp_pkg::COUNT_BITS + 1)'(cmd_q.weight);
		if (sum[wbcp_pkg::COUNT_BITS]) begin
			sat = '1;
		end else begin
			sat = sum[wbcp_pkg::COUNT_BITS-1:0];
		end
		fed_row = rd_row_q;
		for (int i = 0; i < wbcp_pkg::NUM_BASES; i++) begin
			if (2'(i) == cmd_q.base) begin
				fed_row[i*wbcp_pkg::COUNT_BITS +: wbcp_pkg::COUNT_BITS] = sat;
			end
		end
	end

	always_comb begin
		best = 2'd0;
		for (int i = 1; i < wbcp_pkg::NUM_BASES; i++) begin
			if (cnt[i] >= cnt[best]) begin
				best = 2'(i);
			end
		end
		any_vote = (rd_row_q != '0);
		if (cmd_q.in_range && any_vote) begin
			call       = {1'b0, best};
			call_depth = wbcp_pkg::DEPTH_BITS'(cnt[best]);
		end else begin
			call       = wbcp_pkg::CALL_N;
			call_depth = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wbcp_pkg::BK_CLEAR: begin
				if (clr_last) begin
					state_d = wbcp_pkg::BK_IDLE;
				end
			end
			wbcp_pkg::BK_IDLE: begin
				if (pop_valid) begin
					state_d = wbcp_pkg::BK_EXEC;
				end
			end
			wbcp_pkg::BK_EXEC: begin
				if (go) begin
					state_d = wbcp_pkg::BK_IDLE;
				end
			end
			default: state_d = wbcp_pkg::BK_CLEAR;
		endcase
	end

	always_comb begin
		pop_ready       = 1'b0;
		rd_en           = 1'b0;
		wr_en           = 1'b0;
		wr_addr         = cmd_q.idx;
		wr_data         = '0;
		load_out        = 1'b0;
		status.clearing = 1'b0;
		unique case (state_q)
			wbcp_pkg::BK_CLEAR: begin
				status.clearing = 1'b1;
				wr_en           = 1'b1;
				wr_addr         = clr_q;
			end
			wbcp_pkg::BK_IDLE: begin
				pop_ready = 1'b1;
				rd_en     = pop_valid;
			end
			wbcp_pkg::BK_EXEC: begin
				if (go) begin
					wr_en    = cmd_q.in_range;
					load_out = cmd_q.is_read;
					if (!cmd_q.is_read) begin
						wr_data = fed_row;
					end
				end
			end
			default: begin
				status.clearing = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_row_q <= mem[pop_data.idx];
			cmd_q    <= pop_data;
		end
		if (load_out) begin
			best_base_q <= call;
			depth_q     <= call_depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wbcp_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wbcp_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign best_base = best_base_q;
	assign depth     = depth_q;

endmodule

// File: tb/sv/weighted_base_consensus_pileup_tb.sv
// Self-checking testbench for the weighted base consensus pileup.
// It runs a directed table and random vote traffic, and checks each call.
// Depends on wbcp_pkg and weighted_base_consensus_pileup.
`timescale 1ns / 100ps

module weighted_base_consensus_pileup_tb;
	import wbcp_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [CALL_BITS-1:0]  best;
		logic [DEPTH_BITS-1:0] depth;
	} call_t;

	typedef struct {
		op_t                    op;
		logic [POS_IN_BITS-1:0] pos;
		logic [CHAR_BITS-1:0]   ch;
		logic [WEIGHT_BITS-1:0] w;
		bit                     pinned;
		call_t                  call;
	} step_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_RUNS
	} rx_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   opcode;
	logic [POS_IN_BITS-1:0] position;
	logic [CHAR_BITS-1:0]   base_char;
	logic [WEIGHT_BITS-1:0] weight;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CALL_BITS-1:0]   best_base;
	logic [DEPTH_BITS-1:0]  depth;

	logic [COUNT_BITS-1:0] votes [NUM_BASES][POSITIONS] = '{default: '0};
	call_t                 calls_due [$];
	step_t                 plan [$];

	bit    row_pinned;
	call_t row_call;
	int    mismatches;
	int    items_taken;
	int    calls_checked;
	int    idle_cycles;
	int    burst_left;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_run = 0;
	logic     rx_hold = 1'b0;

	weighted_base_consensus_pileup u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.position  (position),
		.base_char (base_char),
		.weight    (weight),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.best_base (best_base),
		.depth     (depth)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int base_of(logic [CHAR_BITS-1:0] ch);
		case (ch)
			CHAR_A: return BASE_A;
			CHAR_C: return BASE_C;
			CHAR_G: return BASE_G;
			CHAR_T: return BASE_T;
			default: return -1;
		endcase
	endfunction

	task automatic pileup_apply(input op_t op, input logic [POS_IN_BITS-1:0] pos,
			input logic [CHAR_BITS-1:0] ch, input logic [WEIGHT_BITS-1:0] w,
			output bit has_call, output call_t call);
		int                  b;
		int                  best;
		int                  i;
		logic [COUNT_BITS:0] sum;
		logic [COUNT_BITS-1:0] top;
		has_call = (op == OP_READ);
		call.best = CALL_N;
		call.depth = '0;
		if (int'(pos) >= POSITIONS)
			return;
		if (op == OP_FEED) begin
			b = base_of(ch);
			if (b >= 0) begin
				sum = votes[b][pos] + w;
				votes[b][pos] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_BITS-1:0];
			end
		end else begin
			best = -1;
			top = '0;
			for (i = 0; i < NUM_BASES; i++) begin
				if (votes[i][pos] != '0 && votes[i][pos] >= top) begin
					best = i;
					top = votes[i][pos];
				end
			end
			if (best >= 0) begin
				call.best = best[CALL_BITS-1:0];
				call.depth = top[DEPTH_BITS-1:0];
			end
			for (i = 0; i < NUM_BASES; i++)
				votes[i][pos] = '0;
		end
	endtask

	task automatic flag(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		bit    has_call;
		call_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				items_taken++;
				pileup_apply(op_t'(opcode), position, base_char, weight, has_call, want);
				if (has_call) begin
					if (row_pinned)
						want = row_call;
					calls_due = {calls_due, want};
				end
			end
			if (out_valid && out_ready) begin
				calls_checked++;
				if (calls_due.size() == 0) begin
					flag($sformatf("unexpected call base %0d depth %0h", best_base, depth));
				end else begin
					want = calls_due.pop_front();
					if (best_base !== want.best)
						flag($sformatf("call %0d best_base got %0d want %0d",
							calls_checked, best_base, want.best));
					if (depth !== want.depth)
						flag($sformatf("call %0d depth got %0h want %0h",
							calls_checked, depth, want.depth));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout after %0d idle cycles, %0d calls still due",
				idle_cycles, calls_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_run == 0) begin
					rx_hold = ~rx_hold;
					rx_run = $urandom_range(1, 15);
				end
				rx_run--;
				out_ready <= rx_hold;
			end
		endcase
	end

	task automatic row(input op_t op, input int pos, input logic [CHAR_BITS-1:0] ch,
			input int w, input bit pinned = 1'b0,
			input logic [CALL_BITS-1:0] best = CALL_N, input int dep = 0);
		step_t s;
		s.op = op;
		s.pos = pos[POS_IN_BITS-1:0];
		s.ch = ch;
		s.w = w[WEIGHT_BITS-1:0];
		s.pinned = pinned;
		s.call.best = best;
		s.call.depth = dep[DEPTH_BITS-1:0];
		plan = {plan, s};
	endtask

	task automatic send_item(input step_t s);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= s.op;
		position <= s.pos;
		base_char <= s.ch;
		weight <= s.w;
		row_pinned = s.pinned;
		row_call = s.call;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic wait_calls_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (calls_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		step_t                  s;
		logic [POS_IN_BITS-1:0] hot [6];
		int                     counted;
		int                     iter;
		int                     r;
		bit                     paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_FEED;
		position = '0;
		base_char = '0;
		weight = '0;
		row_pinned = 1'b0;
		row_call = '0;
		burst_left = 0;

		// Empty columns, a lone vote, clear-on-read, ties, and votes that count for nothing.
		row(OP_READ, 0, CHAR_A, 0, 1'b1, CALL_N, 0);
		row(OP_READ, 1023, CHAR_T, 255, 1'b1, CALL_N, 0);
		row(OP_FEED, 0, CHAR_A, 255);
		row(OP_READ, 0, CHAR_A, 0, 1'b1, {1'b0, BASE_A}, 255);
		row(OP_READ, 0, CHAR_A, 0, 1'b1, CALL_N, 0);
		row(OP_FEED, 1023, CHAR_G, 1);
		row(OP_FEED, 1023, CHAR_T, 1);
		row(OP_READ, 1023, 8'h00, 0);
		row(OP_FEED, 341, CHAR_A, 7);
		row(OP_FEED, 341, CHAR_C, 7);
		row(OP_READ, 341, 8'hFF, 255);
		row(OP_FEED, 682, CHAR_C, 9);
		row(OP_FEED, 682, CHAR_G, 9);
		row(OP_READ, 682, CHAR_C, 0);
		row(OP_FEED, 12, CHAR_A, 0);
		row(OP_READ, 12, CHAR_A, 0, 1'b1, CALL_N, 0);
		row(OP_FEED, 13, 8'h61, 50);
		row(OP_FEED, 13, 8'h4E, 50);
		row(OP_FEED, 13, 8'hFF, 255);
		row(OP_FEED, 13, 8'h00, 128);
		row(OP_READ, 13, CHAR_G, 0, 1'b1, CALL_N, 0);
		row(OP_FEED, 14, CHAR_A, 100);
		row(OP_FEED, 14, CHAR_A, 100);
		row(OP_FEED, 14, CHAR_C, 150);
		row(OP_READ, 14, CHAR_T, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			pace();
			send_item(plan[k]);
		end

		counted = 0;
		iter = 0;
		paused = 1'b0;
		s.pinned = 1'b0;
		s.call = '0;
		while (counted < RANDOM_ITEMS) begin
			if (iter % 100 == 0) begin
				foreach (hot[k])
					hot[k] = POS_IN_BITS'($urandom_range(0, POSITIONS - 1));
			end
			iter++;
			r = $urandom_range(0, 99);
			s.op = (r < 25) ? OP_READ : OP_FEED;
			s.pos = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 5)]
				: POS_IN_BITS'($urandom_range(0, POSITIONS - 1));
			case ($urandom_range(0, 19))
				0, 1, 2: s.ch = CHAR_BITS'($urandom_range(0, 255));
				default: begin
					case ($urandom_range(0, 3))
						0: s.ch = CHAR_A;
						1: s.ch = CHAR_C;
						2: s.ch = CHAR_G;
						default: s.ch = CHAR_T;
					endcase
				end
			endcase
			r = $urandom_range(0, 9);
			if (r == 0)
				s.w = '0;
			else if (r == 1)
				s.w = '1;
			else if (r < 4)
				s.w = WEIGHT_BITS'($urandom_range(0, 3));
			else
				s.w = WEIGHT_BITS'($urandom_range(0, 255));
			counted++;
			if (!paused && counted >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_calls_done();
			end
			pace();
			send_item(s);
		end

		wait_calls_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items and %0d checked calls: directed columns, ties,", items_taken,
			calls_checked);
		$display("ignored votes and random bursty vote traffic");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
